>>> hw/rtl/dsa_pkg.sv
`timescale 1ns / 1ps

package dsa_pkg;

  localparam int FUNC_W     = 2;
  localparam int PID_W      = 4;
  localparam int FD_W       = 5;
  localparam int LOW_W      = 6;
  localparam int FILE_W     = 6;
  localparam int STAT_W     = 2;
  localparam int SLOT_OUT_W = 5;
  localparam int CNT_W      = 10;

  localparam logic [CNT_W-1:0] REF_LIMIT = 10'd512;
  localparam logic [CNT_W-1:0] REF_ONE   = 10'd1;

  localparam int PROCESSES_DEF = 16;
  localparam int SLOTS_DEF     = 32;
  localparam int FILES_DEF     = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_DUP   = 2'd1,
    FUNC_FREE  = 2'd2,
    FUNC_QUERY = 2'd3
  } dsa_func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SLOT   = 2'd1,
    STAT_SRC_EMPTY = 2'd2
  } dsa_stat_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_COUNT
  } dsa_state_e;

  typedef struct packed {
    logic capture;
    logic look_en;
    logic count_en;
    logic load;
  } dsa_cmd_t;

  typedef struct packed {
    logic need_count;
  } dsa_stat_t;

endpackage

>>> hw/rtl/dsa_req_if.sv
`timescale 1ns / 1ps

interface dsa_req_if import dsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PID_W-1:0]  pid;
  logic [FD_W-1:0]   fd;
  logic [LOW_W-1:0]  low;
  logic [FILE_W-1:0] file_index;

  modport source (output valid, func, pid, fd, low, file_index, input ready);
  modport sink   (input valid, func, pid, fd, low, file_index, output ready);
endinterface

>>> hw/rtl/dsa_rsp_if.sv
`timescale 1ns / 1ps

interface dsa_rsp_if import dsa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STAT_W-1:0]     status;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  occupied;
  logic [FILE_W-1:0]     held_file;
  logic [CNT_W-1:0]      ref_count;

  modport source (output valid, status, slot, occupied, held_file, ref_count, input ready);
  modport sink   (input valid, status, slot, occupied, held_file, ref_count, output ready);
endinterface

>>> hw/rtl/dsa_ctrl.sv
`timescale 1ns / 1ps

module dsa_ctrl import dsa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_ready_i,
  input  dsa_stat_t stat_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output dsa_cmd_t  cmd_o
);

  dsa_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_room;

  assign out_room = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (out_room) state_d = stat_i.need_count ? ST_COUNT : ST_IDLE;
      end
      ST_COUNT: begin
        if (out_room) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.capture  = 1'b0;
    cmd_o.look_en  = 1'b0;
    cmd_o.count_en = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_LOOK:  cmd_o.look_en  = out_room;
      ST_COUNT: cmd_o.count_en = out_room;
      default: ;
    endcase
    cmd_o.load = (cmd_o.look_en && !stat_i.need_count) || cmd_o.count_en;
  end

  always_comb begin
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/dsa_datapath.sv
`timescale 1ns / 1ps

module dsa_datapath import dsa_pkg::*; #(
  parameter int PROCESSES = PROCESSES_DEF,
  parameter int SLOTS     = SLOTS_DEF,
  parameter int FILES     = FILES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dsa_cmd_t              cmd_i,
  output dsa_stat_t             stat_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [PID_W-1:0]      pid_i,
  input  logic [FD_W-1:0]       fd_i,
  input  logic [LOW_W-1:0]      low_i,
  input  logic [FILE_W-1:0]     file_index_i,
  output logic [STAT_W-1:0]     status_o,
  output logic [SLOT_OUT_W-1:0] slot_o,
  output logic                  occupied_o,
  output logic [FILE_W-1:0]     held_file_o,
  output logic [CNT_W-1:0]      ref_count_o
);

  localparam int PW        = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int SW        = $clog2(SLOTS);
  localparam int FW        = $clog2(FILES);
  localparam int MEM_DEPTH = PROCESSES << SW;
  localparam int AW        = $clog2(MEM_DEPTH);

  logic [PW-1:0] pid_map  [2**PID_W];
  logic [SW-1:0] fd_map   [2**FD_W];
  logic [FW-1:0] file_map [2**FILE_W];

  for (genvar i = 0; i < 2**PID_W; i++) begin : g_pid_map
    assign pid_map[i] = PW'(i % PROCESSES);
  end
  for (genvar i = 0; i < 2**FD_W; i++) begin : g_fd_map
    assign fd_map[i] = SW'(i % SLOTS);
  end
  for (genvar i = 0; i < 2**FILE_W; i++) begin : g_file_map
    assign file_map[i] = FW'(i % FILES);
  end

  dsa_func_e         func_q;
  logic [PW-1:0]     p_q;
  logic [SW-1:0]     fd_q;
  logic [LOW_W-1:0]  low_q;
  logic [FILE_W-1:0] fi_q;

  logic [SLOTS-1:0]  used_q [PROCESSES];
  logic [SLOTS-1:0]  used_d [PROCESSES];

  logic [FILE_W-1:0] slot_mem [MEM_DEPTH];
  logic [CNT_W-1:0]  ref_mem  [FILES];
  logic [FILE_W-1:0] slot_rdata_q;
  logic [CNT_W-1:0]  ref_rdata_q;

  logic [SLOTS-1:0]  used_row;
  logic              src_used;
  logic [LOW_W-1:0]  start;
  logic [SLOTS-1:0]  elig;
  logic              found;
  logic [SW-1:0]     free_slot;
  logic [CNT_W-1:0]  cnt_inc;
  logic [FW-1:0]     ref_raddr;

  logic              slot_we;
  logic [AW-1:0]     slot_waddr;
  logic [FILE_W-1:0] slot_wdata;
  logic              ref_we;
  logic [FW-1:0]     ref_waddr;
  logic [CNT_W-1:0]  ref_wdata;
  logic              do_alloc;

  logic [STAT_W-1:0]     status_d;
  logic [SLOT_OUT_W-1:0] slot_d;
  logic                  occupied_d;
  logic [FILE_W-1:0]     held_file_d;
  logic [CNT_W-1:0]      ref_count_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= dsa_func_e'(func_i);
      p_q    <= pid_map[pid_i];
      fd_q   <= fd_map[fd_i];
      low_q  <= low_i;
      fi_q   <= file_index_i;
    end
  end

  assign used_row = used_q[p_q];
  assign src_used = used_row[fd_q];
  assign start    = (func_q == FUNC_DUP) ? low_q : '0;

  always_comb begin
    found     = 1'b0;
    free_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      elig[i] = !used_row[i] && (32'(i) >= 32'(start));
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (elig[i]) begin
        found     = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

  assign stat_o.need_count = (func_q == FUNC_DUP) && src_used && found;
  assign do_alloc  = cmd_i.look_en && (func_q == FUNC_ALLOC) && found;
  assign ref_raddr = file_map[slot_rdata_q];
  assign cnt_inc   = (ref_rdata_q < REF_LIMIT) ? ref_rdata_q + REF_ONE : ref_rdata_q;

  always_comb begin
    used_d = used_q;
    if (do_alloc || cmd_i.count_en) begin
      used_d[p_q][free_slot] = 1'b1;
    end
    if (cmd_i.look_en && (func_q == FUNC_FREE) && src_used) begin
      used_d[p_q][fd_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '{default: '0};
    end else begin
      used_q <= used_d;
    end
  end

  assign slot_we    = do_alloc || cmd_i.count_en;
  assign slot_waddr = AW'({p_q, free_slot});
  assign slot_wdata = cmd_i.count_en ? slot_rdata_q : fi_q;

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (cmd_i.capture) begin
      slot_rdata_q <= slot_mem[AW'({pid_map[pid_i], fd_map[fd_i]})];
    end
  end

  assign ref_we    = do_alloc || cmd_i.count_en;
  assign ref_waddr = cmd_i.count_en ? ref_raddr : file_map[fi_q];
  assign ref_wdata = cmd_i.count_en ? cnt_inc : REF_ONE;

  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    ref_rdata_q <= ref_mem[ref_raddr];
  end

  always_comb begin
    status_d    = STAT_OK;
    slot_d      = '0;
    occupied_d  = 1'b0;
    held_file_d = '0;
    ref_count_d = '0;
    if (cmd_i.count_en) begin
      slot_d      = SLOT_OUT_W'(free_slot);
      occupied_d  = 1'b1;
      held_file_d = slot_rdata_q;
      ref_count_d = cnt_inc;
    end else begin
      case (func_q)
        FUNC_ALLOC: begin
          if (found) begin
            slot_d      = SLOT_OUT_W'(free_slot);
            occupied_d  = 1'b1;
            held_file_d = fi_q;
            ref_count_d = REF_ONE;
          end else begin
            status_d = STAT_NO_SLOT;
          end
        end
        FUNC_DUP: begin
          status_d = src_used ? STAT_NO_SLOT : STAT_SRC_EMPTY;
        end
        FUNC_FREE, FUNC_QUERY: begin
          occupied_d  = src_used;
          held_file_d = src_used ? slot_rdata_q : '0;
        end
        default: status_d = STAT_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_o    <= status_d;
      slot_o      <= slot_d;
      occupied_o  <= occupied_d;
      held_file_o <= held_file_d;
      ref_count_o <= ref_count_d;
    end
  end

endmodule

>>> hw/rtl/descriptor_slot_allocator.sv
`timescale 1ns / 1ps

// Lowest-free-slot descriptor allocator. A request is accepted only while the block is idle.
// The result register is loaded in the look state that follows acceptance, or in the count
// state after it for a duplicate that finds a free slot, as its reference-count read is
// addressed by the file index that the slot memory read returns. Both states hold while
// the previous result still waits in the output register, and no new request is taken
// until the block is back in idle. A finished result may wait there while the next
// request is accepted; that request then holds before loading until the output is taken.
// No clearing pass is needed after reset: occupancy words reset at once, and slot and count
// entries are only read once written.
module descriptor_slot_allocator import dsa_pkg::*; #(
  parameter int PROCESSES = PROCESSES_DEF,
  parameter int SLOTS     = SLOTS_DEF,
  parameter int FILES     = FILES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsa_req_if.sink   req,
  dsa_rsp_if.source rsp
);

  dsa_cmd_t  cmd;
  dsa_stat_t stat;
  logic      in_ready;
  logic      out_valid;

  dsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .out_ready_i (rsp.ready),
    .stat_i      (stat),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  dsa_datapath #(
    .PROCESSES (PROCESSES),
    .SLOTS     (SLOTS),
    .FILES     (FILES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .func_i       (req.func),
    .pid_i        (req.pid),
    .fd_i         (req.fd),
    .low_i        (req.low),
    .file_index_i (req.file_index),
    .status_o     (rsp.status),
    .slot_o       (rsp.slot),
    .occupied_o   (rsp.occupied),
    .held_file_o  (rsp.held_file),
    .ref_count_o  (rsp.ref_count)
  );

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

`ifndef SYNTHESIS
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while previous one still in work");

  a_load_with_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!rsp.valid || rsp.ready))
    else $error("result loaded over a waiting result");

  a_single_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.look_en && cmd.count_en) && !(cmd.capture && (cmd.look_en || cmd.count_en)))
    else $error("controller phases overlap");

  a_fail_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && (rsp.status != STAT_OK) |-> (rsp.ref_count == '0) && !rsp.occupied)
    else $error("failed request reports a slot");
`endif

endmodule

>>> verif/descriptor_slot_allocator_tb.sv
`timescale 1ns / 1ps

module descriptor_slot_allocator_tb;
  import dsa_pkg::*;

  typedef struct packed {
    dsa_func_e         func;
    logic [PID_W-1:0]  pid;
    logic [FD_W-1:0]   fd;
    logic [LOW_W-1:0]  low;
    logic [FILE_W-1:0] file_index;
  } slot_req_t;

  typedef struct packed {
    dsa_stat_e             status;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  occupied;
    logic [FILE_W-1:0]     held_file;
    logic [CNT_W-1:0]      ref_count;
  } slot_outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dsa_req_if req_if ();
  dsa_rsp_if rsp_if ();

  descriptor_slot_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if),
    .rsp    (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  logic [SLOTS_DEF-1:0]   occ_map       [PROCESSES_DEF];
  logic [FILE_W-1:0]      slot_contents [PROCESSES_DEF][SLOTS_DEF];
  logic [CNT_W-1:0]       ref_table     [FILES_DEF];

  slot_outcome_t outcome_q [$];
  slot_outcome_t last_outcome;
  slot_outcome_t exp_o;

  bit idle_on;
  bit hold_rsp;
  int errors;
  int sent;
  int checked;
  int func_seen [4];
  int no_slot_seen;
  int src_empty_seen;
  int saturated_seen;

  function automatic int lowest_free(int p, int start);
    for (int s = start; s < SLOTS_DEF; s++)
      if (!occ_map[p][s]) return s;
    return -1;
  endfunction

  function automatic slot_outcome_t resolve_request(slot_req_t r);
    slot_outcome_t o;
    int s;
    int idx;
    logic [FILE_W-1:0] f;
    o = '0;
    o.status = STAT_OK;
    case (r.func)
      FUNC_ALLOC: begin
        s = lowest_free(r.pid, 0);
        if (s < 0) begin
          o.status = STAT_NO_SLOT;
        end else begin
          idx = r.file_index % FILES_DEF;
          occ_map[r.pid][s] = 1'b1;
          slot_contents[r.pid][s] = r.file_index;
          ref_table[idx] = REF_ONE;
          o.slot = SLOT_OUT_W'(s);
          o.occupied = 1'b1;
          o.held_file = r.file_index;
          o.ref_count = REF_ONE;
        end
      end
      FUNC_DUP: begin
        if (!occ_map[r.pid][r.fd]) begin
          o.status = STAT_SRC_EMPTY;
        end else begin
          s = (r.low < SLOTS_DEF) ? lowest_free(r.pid, r.low) : -1;
          if (s < 0) begin
            o.status = STAT_NO_SLOT;
          end else begin
            f = slot_contents[r.pid][r.fd];
            idx = f % FILES_DEF;
            occ_map[r.pid][s] = 1'b1;
            slot_contents[r.pid][s] = f;
            if (ref_table[idx] < REF_LIMIT) ref_table[idx] = ref_table[idx] + 1'b1;
            else saturated_seen++;
            o.slot = SLOT_OUT_W'(s);
            o.occupied = 1'b1;
            o.held_file = f;
            o.ref_count = ref_table[idx];
          end
        end
      end
      default: begin
        if (occ_map[r.pid][r.fd]) begin
          o.occupied = 1'b1;
          o.held_file = slot_contents[r.pid][r.fd];
          if (r.func == FUNC_FREE) occ_map[r.pid][r.fd] = 1'b0;
        end
      end
    endcase
    if (o.status == STAT_NO_SLOT) no_slot_seen++;
    if (o.status == STAT_SRC_EMPTY) src_empty_seen++;
    return o;
  endfunction

  function automatic slot_req_t mk_req(dsa_func_e f, int pid, int fd, int low, int fi);
    slot_req_t r;
    r.func = f;
    r.pid = PID_W'(pid);
    r.fd = FD_W'(fd);
    r.low = LOW_W'(low);
    r.file_index = FILE_W'(fi);
    return r;
  endfunction

  function automatic slot_req_t rand_req(int alloc_pct);
    slot_req_t r;
    int pick;
    int tries;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) r.func = FUNC_ALLOC;
    else begin
      pick = $urandom_range(0, 99);
      r.func = (pick < 40) ? FUNC_DUP : (pick < 75) ? FUNC_FREE : FUNC_QUERY;
    end
    r.pid = ($urandom_range(0, 9) < 7) ? PID_W'($urandom_range(0, 3)) : PID_W'($urandom);
    r.fd = FD_W'($urandom);
    tries = 0;
    while (!occ_map[r.pid][r.fd] && tries < 8 && $urandom_range(0, 3) != 0) begin
      r.fd = FD_W'($urandom);
      tries++;
    end
    pick = $urandom_range(0, 9);
    r.low = (pick == 0) ? '0 : (pick == 1) ? LOW_W'($urandom_range(32, 63))
          : LOW_W'($urandom_range(0, 31));
    r.file_index = FILE_W'($urandom);
    return r;
  endfunction

  task automatic send_req(input slot_req_t r);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      req_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.func       = r.func;
    req_if.pid        = r.pid;
    req_if.fd         = r.fd;
    req_if.low        = r.low;
    req_if.file_index = r.file_index;
    req_if.valid      = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    last_outcome = resolve_request(r);
    outcome_q.push_back(last_outcome);
    func_seen[r.func]++;
    sent++;
  endtask

  task automatic cmp_field(string name, logic [CNT_W-1:0] expv, logic [CNT_W-1:0] act);
    if (act !== expv) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, act);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (outcome_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                 $time, rsp_if.status, rsp_if.slot);
      end else begin
        exp_o = outcome_q.pop_front();
        cmp_field("status", CNT_W'(exp_o.status), CNT_W'(rsp_if.status));
        cmp_field("slot", CNT_W'(exp_o.slot), CNT_W'(rsp_if.slot));
        cmp_field("occupied", CNT_W'(exp_o.occupied), CNT_W'(rsp_if.occupied));
        cmp_field("held_file", CNT_W'(exp_o.held_file), CNT_W'(rsp_if.held_file));
        cmp_field("ref_count", exp_o.ref_count, rsp_if.ref_count);
        checked++;
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) stall--;
      else if (idle_on && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 7);
      rsp_if.ready = (stall == 0) && !hold_rsp;
    end
  end

  task automatic test_directed();
    send_req(mk_req(FUNC_ALLOC, 0, 0, 0, 63));
    send_req(mk_req(FUNC_ALLOC, 0, 0, 0, 0));
    send_req(mk_req(FUNC_QUERY, 0, 0, 0, 0));
    send_req(mk_req(FUNC_QUERY, 0, 31, 0, 0));
    send_req(mk_req(FUNC_DUP, 0, 5, 0, 0));
    send_req(mk_req(FUNC_DUP, 0, 0, 31, 0));
    send_req(mk_req(FUNC_DUP, 0, 0, 32, 0));
    send_req(mk_req(FUNC_DUP, 0, 1, 0, 21));
    send_req(mk_req(FUNC_FREE, 0, 0, 0, 0));
    send_req(mk_req(FUNC_FREE, 0, 0, 0, 0));
    send_req(mk_req(FUNC_ALLOC, 0, 0, 0, 0));
    send_req(mk_req(FUNC_DUP, 0, 2, 0, 0));
    send_req(mk_req(FUNC_ALLOC, 15, 31, 63, 42));
    send_req(mk_req(FUNC_QUERY, 15, 31, 63, 63));
    send_req(mk_req(FUNC_QUERY, 15, 0, 0, 0));
    send_req(mk_req(FUNC_FREE, 15, 0, 0, 0));
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 33; i++)
      send_req(mk_req(FUNC_ALLOC, 15, 0, 0, $urandom_range(0, 63)));
    send_req(mk_req(FUNC_DUP, 15, 3, 0, 0));
    send_req(mk_req(FUNC_FREE, 15, 0, 0, 0));
    // source empty while nothing above the bound is free
    send_req(mk_req(FUNC_DUP, 15, 0, 1, 0));
    send_req(mk_req(FUNC_DUP, 15, 4, 32, 0));
    send_req(mk_req(FUNC_DUP, 15, 4, 63, 0));
    send_req(mk_req(FUNC_DUP, 15, 4, 0, 0));
    send_req(mk_req(FUNC_FREE, 15, 31, 0, 0));
    send_req(mk_req(FUNC_QUERY, 15, 31, 0, 0));
    send_req(mk_req(FUNC_ALLOC, 15, 0, 0, 7));
  endtask

  task automatic test_ref_saturation();
    logic [FD_W-1:0] src;
    send_req(mk_req(FUNC_ALLOC, 6, 0, 0, 37));
    src = last_outcome.slot;
    // duplicate and drop the copy until the count pins at its limit
    for (int i = 0; i < 515; i++) begin
      send_req(mk_req(FUNC_DUP, 6, src, 0, 0));
      if (last_outcome.status == STAT_OK)
        send_req(mk_req(FUNC_FREE, 6, last_outcome.slot, 0, 0));
    end
    send_req(mk_req(FUNC_ALLOC, 6, 0, 0, 37));
    send_req(mk_req(FUNC_DUP, 6, src, 0, 0));
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rsp = 1'b1;
        repeat (80) @(negedge clk_i);
        hold_rsp = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++) send_req(rand_req(40));
      end
    join
  endtask

  task automatic test_random(int n, int alloc_pct);
    for (int i = 0; i < n; i++) send_req(rand_req(alloc_pct));
  endtask

  initial begin
    int waited;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.func       = FUNC_ALLOC;
    req_if.pid        = '0;
    req_if.fd         = '0;
    req_if.low        = '0;
    req_if.file_index = '0;
    idle_on           = 1'b1;
    hold_rsp          = 1'b0;
    for (int p = 0; p < PROCESSES_DEF; p++) occ_map[p] = '0;
    for (int f = 0; f < FILES_DEF; f++) ref_table[f] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_table_full();
    test_ref_saturation();
    test_backpressure();
    test_random(110, 55);
    test_random(110, 20);
    idle_on = 1'b0;
    test_random(90, 35);

    @(negedge clk_i);
    req_if.valid = 1'b0;
    waited = 0;
    while (outcome_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (outcome_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results expected but never delivered", $time, outcome_q.size());
    end

    $display("Sent %0d requests (alloc %0d, dup %0d, free %0d, query %0d), checked %0d.",
             sent, func_seen[FUNC_ALLOC], func_seen[FUNC_DUP], func_seen[FUNC_FREE],
             func_seen[FUNC_QUERY], checked);
    $display("No-slot %0d, empty source %0d, saturated count %0d, mismatches %0d.",
             no_slot_seen, src_empty_seen, saturated_seen, errors);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d results still outstanding", $time, outcome_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/dsa_pkg.sv
hw/rtl/dsa_req_if.sv
hw/rtl/dsa_rsp_if.sv
hw/rtl/dsa_ctrl.sv
hw/rtl/dsa_datapath.sv
hw/rtl/descriptor_slot_allocator.sv
verif/descriptor_slot_allocator_tb.sv
